FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("check failed");
`endif

FILE: design/sdtq_pkg.sv
// Package for the sorted deadline timer queue: item types, codes and sizes.
// No dependencies.
package sdtq_pkg;
  localparam int NUM_TIMERS = 64;
  localparam int IDW = 6;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_ADJ = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  timer_id;
    logic [31:0] deadline;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [5:0] expired_id;
    logic       last_result;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_INSERT, CMD_REMOVE, CMD_MOVE, CMD_TICK
  } cmd_kind_t;

  // Command passed from the front end to the queue engine.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [5:0]  id;
    logic [31:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_REMOVE, ST_INSERT, ST_POP
  } eng_state_t;
endpackage

FILE: design/sdtq_front.sv
// Front end: checks each item against the presence map, answers add, adjust and
// delete at once and queues commands for the engine. Uses sdtq_pkg.
module sdtq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdtq_pkg::in_item_t  in_item,
  output logic                ack_valid,
  output sdtq_pkg::out_item_t ack_item,
  input  logic                ack_take,
  output logic                cmd_valid,
  output sdtq_pkg::cmd_t      cmd,
  input  logic                cmd_take,
  input  logic                clr_valid,
  input  logic [5:0]          clr_id,
  input  logic                eng_busy
);
  logic [sdtq_pkg::NUM_TIMERS-1:0] present_r, present_nxt;
  sdtq_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic tick_busy_r, tick_busy_nxt;
  logic ackv_r;
  sdtq_pkg::out_item_t ack_r;
  logic accept, ok, pres, isq;
  sdtq_pkg::cmd_t ncmd;

  assign pres = (32'(in_item.timer_id) < sdtq_pkg::NUM_TIMERS) &&
                present_r[in_item.timer_id[$clog2(sdtq_pkg::NUM_TIMERS)-1:0]];
  assign in_stall = (cnt_r == 2'd2) || tick_busy_r || eng_busy || (ackv_r && !ack_take);
  assign accept = in_valid && !in_stall;

  always_comb begin
    ok = 1'b0;
    isq = 1'b0;
    ncmd.id = in_item.timer_id;
    ncmd.value = in_item.deadline;
    ncmd.kind = sdtq_pkg::CMD_INSERT;
    unique case (in_item.opcode)
      sdtq_pkg::OP_ADD: begin
        ok = (32'(in_item.timer_id) < sdtq_pkg::NUM_TIMERS) && !pres;
        isq = ok;
      end
      sdtq_pkg::OP_ADJ: begin
        ok = pres; isq = ok; ncmd.kind = sdtq_pkg::CMD_MOVE;
      end
      sdtq_pkg::OP_DEL: begin
        ok = pres; isq = ok; ncmd.kind = sdtq_pkg::CMD_REMOVE;
      end
      default: begin
        isq = 1'b1; ncmd.kind = sdtq_pkg::CMD_TICK; ncmd.value = in_item.now_time;
      end
    endcase
  end

  always_comb begin
    present_nxt = present_r;
    if (clr_valid) present_nxt[clr_id[$clog2(sdtq_pkg::NUM_TIMERS)-1:0]] = 1'b0;
    if (accept && ok) begin
      present_nxt[in_item.timer_id[$clog2(sdtq_pkg::NUM_TIMERS)-1:0]] =
        (in_item.opcode != sdtq_pkg::OP_DEL);
    end
    cnt_nxt = cnt_r + {1'b0, accept && isq} - {1'b0, cmd_take};
    tick_busy_nxt = tick_busy_r;
    if (accept && in_item.opcode == sdtq_pkg::OP_TICK) tick_busy_nxt = 1'b1;
    else if (cmd_take && cmd.kind == sdtq_pkg::CMD_TICK) tick_busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      tick_busy_r <= 1'b0;
      ackv_r <= 1'b0;
    end else begin
      present_r <= present_nxt;
      cnt_r <= cnt_nxt;
      tick_busy_r <= tick_busy_nxt;
      if (accept && isq) wp_r <= !wp_r;
      if (cmd_take) rp_r <= !rp_r;
      if (accept && in_item.opcode != sdtq_pkg::OP_TICK) ackv_r <= 1'b1;
      else if (ack_take) ackv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && isq) q_r[wp_r] <= ncmd;
    if (accept && in_item.opcode != sdtq_pkg::OP_TICK) begin
      ack_r.result_kind <= ok ? sdtq_pkg::KIND_ACK : sdtq_pkg::KIND_ERROR;
      ack_r.expired_id <= in_item.timer_id;
      ack_r.last_result <= 1'b1;
    end
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];
  assign ack_valid = ackv_r;
  assign ack_item = ack_r;
endmodule

FILE: design/sdtq_engine.sv
// Back end: the sorted shift-register queue that inserts, removes and pops.
// Uses sdtq_pkg.
module sdtq_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  sdtq_pkg::cmd_t      cmd,
  output logic                cmd_take,
  output logic                res_valid,
  output sdtq_pkg::out_item_t res_item,
  input  logic                res_stall,
  output logic                clr_valid,
  output logic [5:0]          clr_id,
  output logic                eng_busy
);
  localparam int N = sdtq_pkg::NUM_TIMERS;
  logic [5:0]  ids_r [N];
  logic [31:0] dls_r [N];
  logic [sdtq_pkg::CW-1:0] cnt_r, cnt_nxt;
  sdtq_pkg::eng_state_t st_r, st_nxt;
  sdtq_pkg::cmd_t c_r;
  logic resv_r;
  sdtq_pkg::out_item_t res_r;
  logic [N-1:0] le, hit, occ;
  logic do_ins, do_rem, do_pop, pop_more, pop_any, out_free;

  assign out_free = !resv_r || !res_stall;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      occ[i] = (i < 32'(cnt_r));
      le[i] = occ[i] && (dls_r[i] <= c_r.value);
      hit[i] = occ[i] && (ids_r[i] == c_r.id);
    end
  end
  assign pop_any = le[0];
  assign pop_more = (cnt_r > sdtq_pkg::CW'(1)) && (dls_r[1] <= c_r.value);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sdtq_pkg::ST_IDLE: if (cmd_valid) begin
        unique case (cmd.kind)
          sdtq_pkg::CMD_INSERT: st_nxt = sdtq_pkg::ST_INSERT;
          sdtq_pkg::CMD_TICK:   st_nxt = sdtq_pkg::ST_POP;
          default:              st_nxt = sdtq_pkg::ST_REMOVE;
        endcase
      end
      sdtq_pkg::ST_REMOVE:
        st_nxt = (c_r.kind == sdtq_pkg::CMD_MOVE) ? sdtq_pkg::ST_INSERT : sdtq_pkg::ST_IDLE;
      sdtq_pkg::ST_INSERT: st_nxt = sdtq_pkg::ST_IDLE;
      default: if (out_free && (!pop_any || !pop_more)) st_nxt = sdtq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = (st_r == sdtq_pkg::ST_IDLE) && cmd_valid;
    do_rem = (st_r == sdtq_pkg::ST_REMOVE);
    do_ins = (st_r == sdtq_pkg::ST_INSERT);
    do_pop = (st_r == sdtq_pkg::ST_POP) && out_free && pop_any;
    clr_valid = do_pop;
    clr_id = ids_r[0];
    cnt_nxt = cnt_r;
    if (do_rem) cnt_nxt = cnt_r - sdtq_pkg::CW'(1);
    if (do_ins) cnt_nxt = cnt_r + sdtq_pkg::CW'(1);
    if (do_pop) cnt_nxt = cnt_r - sdtq_pkg::CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sdtq_pkg::ST_IDLE;
      cnt_r <= '0;
      resv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      if ((st_r == sdtq_pkg::ST_POP) && out_free) resv_r <= 1'b1;
      else if (!res_stall) resv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) c_r <= cmd;
    if ((st_r == sdtq_pkg::ST_POP) && out_free) begin
      res_r.result_kind <= pop_any ? sdtq_pkg::KIND_EXPIRED : sdtq_pkg::KIND_ACK;
      res_r.expired_id <= pop_any ? ids_r[0] : 6'd0;
      res_r.last_result <= !(pop_any && pop_more);
    end
    for (int i = 0; i < N; i++) begin
      if (do_pop || (do_rem && (|(hit & ((N'(1) << i) - N'(1))) || hit[i]))) begin
        if (i < N - 1) begin
          ids_r[i] <= ids_r[(i < N - 1) ? i + 1 : i];
          dls_r[i] <= dls_r[(i < N - 1) ? i + 1 : i];
        end
      end else if (do_ins && !le[i]) begin
        if (i == 0 || le[(i > 0) ? i - 1 : 0]) begin
          ids_r[i] <= c_r.id;
          dls_r[i] <= c_r.value;
        end else begin
          ids_r[i] <= ids_r[(i > 0) ? i - 1 : 0];
          dls_r[i] <= dls_r[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  assign res_valid = resv_r;
  assign res_item = res_r;
  assign eng_busy = (st_r == sdtq_pkg::ST_POP) || resv_r;
endmodule

FILE: design/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue.
// Depends on sdtq_pkg, sdtq_front and sdtq_engine.
//
// Items enter on in_valid/in_stall and results leave on out_valid/out_stall.
// Add, adjust and delete give one result, checked and answered by the front
// end in the cycle after acceptance; their queue work follows in the engine:
// delete passes through a remove state, add an insert state, adjust both,
// and a small command queue lets new items arrive meanwhile. A tick waits
// for earlier queue work, then pops one expired entry per cycle while the
// result side does not stall, each result registered; with nothing expired
// it gives one acknowledge. No new item is accepted until the last result of
// a tick has been taken. The queue is a shift register with one compare per
// slot. Reset empties the queue and the presence map at once. A stall on the
// result side holds the current result and backs up into the front end.
module sorted_deadline_timer_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdtq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sdtq_pkg::out_item_t out_item
);
  logic ack_valid, ack_take, cmd_valid, cmd_take, res_valid, clr_valid, eng_busy;
  sdtq_pkg::out_item_t ack_item, res_item;
  sdtq_pkg::cmd_t cmd;
  logic [5:0] clr_id;

  sdtq_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item,
    .ack_valid, .ack_item, .ack_take,
    .cmd_valid, .cmd, .cmd_take, .clr_valid, .clr_id, .eng_busy
  );

  sdtq_engine u_engine (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
    .res_valid, .res_item, .res_stall(out_stall || ack_valid),
    .clr_valid, .clr_id, .eng_busy
  );

  assign ack_take = ack_valid && !out_stall;
  assign out_valid = ack_valid || res_valid;
  assign out_item = ack_valid ? ack_item : res_item;
endmodule

FILE: design/sdtq_checker.sv
// Port checker for the sorted deadline timer queue, bound to the top level.
// Depends on sdtq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sdtq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input sdtq_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input sdtq_pkg::out_item_t out_item
);
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
  `CHK_IMPL(a_kind, clk, rst_n, out_valid, out_item.result_kind != 2'd3)
  `CHK_IMPL(a_exp_last, clk, rst_n, out_valid && out_item.result_kind == sdtq_pkg::KIND_ERROR,
    out_item.last_result)
  `CHK_NEXT(a_ack, clk, rst_n,
    in_valid && !in_stall && in_item.opcode != sdtq_pkg::OP_TICK, out_valid)
endmodule

bind sorted_deadline_timer_queue sdtq_checker u_chk (.*);

FILE: tb/sv/sorted_deadline_timer_queue_tb.sv
// Testbench for the sorted deadline timer queue: directed and random items,
// checked against a sorted-list predictor. Depends on sdtq_pkg and the RTL top.
module sorted_deadline_timer_queue_tb;
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  sdtq_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  sdtq_pkg::out_item_t out_item;

  sorted_deadline_timer_queue uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  logic [5:0]          timer_ids[$];
  logic [31:0]         timer_deadlines[$];
  sdtq_pkg::out_item_t pending_results[$];
  int                  fail_count;
  bit                  hold_results;
  bit                  stall_random;
  logic [31:0]         clock_now;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_timer(logic [5:0] id);
    for (int i = 0; i < timer_ids.size(); i++) begin
      if (timer_ids[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void insert_timer(logic [5:0] id, logic [31:0] dl);
    int pos;
    pos = 0;
    while (pos < timer_ids.size() && timer_deadlines[pos] <= dl) pos++;
    timer_ids.insert(pos, id);
    timer_deadlines.insert(pos, dl);
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [5:0] id, logic last);
    sdtq_pkg::out_item_t r;
    r.result_kind = kind;
    r.expired_id = id;
    r.last_result = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_queue(sdtq_pkg::in_item_t it);
    int pos;
    int pops;
    pos = find_timer(it.timer_id);
    pops = 0;
    case (it.opcode)
      sdtq_pkg::OP_TICK: begin
        while (pops < timer_ids.size() && timer_deadlines[pops] <= it.now_time) pops++;
        if (pops == 0) begin
          push_result(sdtq_pkg::KIND_ACK, 6'd0, 1'b1);
        end else begin
          for (int i = 0; i < pops; i++) begin
            push_result(sdtq_pkg::KIND_EXPIRED, timer_ids[0], i == pops - 1);
            void'(timer_ids.pop_front());
            void'(timer_deadlines.pop_front());
          end
        end
      end
      sdtq_pkg::OP_ADD: begin
        if (pos >= 0) begin
          push_result(sdtq_pkg::KIND_ERROR, it.timer_id, 1'b1);
        end else begin
          insert_timer(it.timer_id, it.deadline);
          push_result(sdtq_pkg::KIND_ACK, it.timer_id, 1'b1);
        end
      end
      default: begin
        if (pos < 0) begin
          push_result(sdtq_pkg::KIND_ERROR, it.timer_id, 1'b1);
        end else begin
          timer_ids.delete(pos);
          timer_deadlines.delete(pos);
          if (it.opcode == sdtq_pkg::OP_ADJ) insert_timer(it.timer_id, it.deadline);
          push_result(sdtq_pkg::KIND_ACK, it.timer_id, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_item(logic [1:0] op, logic [5:0] id, logic [31:0] dl,
                           logic [31:0] now);
    sdtq_pkg::in_item_t it;
    int gap;
    it.opcode = op;
    it.timer_id = id;
    it.deadline = dl;
    it.now_time = now;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_queue(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_results) begin
      out_stall <= 1'b1;
    end else if (stall_random) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    sdtq_pkg::out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item.result_kind !== exp_r.result_kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time,
                   exp_r.result_kind, out_item.result_kind);
          fail_count++;
        end
        if (out_item.expired_id !== exp_r.expired_id) begin
          $display("%0t: expired_id expected %0d actual %0d", $time,
                   exp_r.expired_id, out_item.expired_id);
          fail_count++;
        end
        if (out_item.last_result !== exp_r.last_result) begin
          $display("%0t: last_result expected %0d actual %0d", $time,
                   exp_r.last_result, out_item.last_result);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(sdtq_pkg::OP_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(sdtq_pkg::OP_ADJ, 6'd5, 32'd10, 32'd0);
    send_item(sdtq_pkg::OP_DEL, 6'd63, 32'd0, 32'd0);
    send_item(sdtq_pkg::OP_ADD, 6'd0, 32'hFFFF_FFFF, 32'd0);
    send_item(sdtq_pkg::OP_ADD, 6'd63, 32'd0, 32'hFFFF_FFFF);
    send_item(sdtq_pkg::OP_ADD, 6'd10, 32'd100, 32'd0);
    send_item(sdtq_pkg::OP_ADD, 6'd11, 32'd100, 32'd0);
    send_item(sdtq_pkg::OP_ADD, 6'd12, 32'd100, 32'd0);
    send_item(sdtq_pkg::OP_ADD, 6'd10, 32'd5, 32'd0);
    send_item(sdtq_pkg::OP_ADJ, 6'd12, 32'd50, 32'd0);
    send_item(sdtq_pkg::OP_ADJ, 6'd10, 32'd200, 32'd0);
    send_item(sdtq_pkg::OP_ADJ, 6'd11, 32'd100, 32'd0);
    send_item(sdtq_pkg::OP_TICK, 6'd0, 32'd0, 32'd49);
    send_item(sdtq_pkg::OP_TICK, 6'd0, 32'd0, 32'd100);
    send_item(sdtq_pkg::OP_DEL, 6'd10, 32'd0, 32'd0);
    send_item(sdtq_pkg::OP_DEL, 6'd10, 32'd0, 32'd0);
    send_item(sdtq_pkg::OP_TICK, 6'd0, 32'd0, 32'hFFFF_FFFE);
    send_item(sdtq_pkg::OP_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < 64; i++) begin
      send_item(sdtq_pkg::OP_ADD, i[5:0], $urandom_range(0, 20), 32'd0);
    end
    send_item(sdtq_pkg::OP_TICK, 6'd0, 32'd0, 32'd20);
    wait_drained();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_results = 1'b1;
        repeat (200) @(posedge clk);
        hold_results = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) begin
          send_item(sdtq_pkg::OP_ADD, 6'($urandom_range(0, 63)), $urandom_range(0, 50),
                    32'd0);
        end
      end
    join
    send_item(sdtq_pkg::OP_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_random();
    logic [1:0]  op;
    logic [5:0]  id;
    logic [31:0] dl;
    clock_now = 32'd1000;
    for (int n = 0; n < 24; n++) begin
      op = 2'($urandom_range(0, 3));
      if (timer_ids.size() != 0 && $urandom_range(0, 2) != 0 && op != sdtq_pkg::OP_ADD) begin
        id = timer_ids[$urandom_range(0, timer_ids.size() - 1)];
      end else begin
        id = 6'($urandom_range(0, 63));
      end
      if ($urandom_range(0, 9) == 0) begin
        dl = $urandom();
      end else begin
        dl = clock_now + $urandom_range(0, 60);
      end
      if (op == sdtq_pkg::OP_TICK) clock_now = clock_now + $urandom_range(0, 30);
      if ($urandom_range(0, 19) == 0) begin
        send_item(op, id, dl, $urandom());
      end else begin
        send_item(op, id, dl, clock_now);
      end
    end
    send_item(sdtq_pkg::OP_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    fail_count = 0;
    hold_results = 1'b0;
    stall_random = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_random = 1'b1;
    test_full_queue();
    test_backpressure();
    test_random();
    stall_random = 1'b0;
    test_random();
    if (fail_count == 0) begin
      $display("sorted_deadline_timer_queue: match");
    end else begin
      $display("sorted_deadline_timer_queue: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sorted_deadline_timer_queue: mismatch");
    $finish;
  end
endmodule
